[design/mmp_pkg.sv]
// Shared types and codes for the MIDI message parser.
// No dependencies; used by mmp_decoder and midi_message_parser.
`timescale 1ns / 1ps
`default_nettype none

package mmp_pkg;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int CHAN_W  = 4;
    localparam int DATA_W  = 7;
    localparam int MSG_W   = KIND_W + CHAN_W + 2 * DATA_W;
    localparam int M_TDATA_W = ((MSG_W + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] SYSEX_START = 8'hF0;
    localparam logic [BYTE_W-1:0] SYSEX_END   = 8'hF7;
    localparam logic [3:0]        SYSTEM_NIB  = 4'hF;

    localparam logic [KIND_W-1:0] KIND_NOTE_OFF  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_NOTE_ON   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_POLY      = 3'd2;
    localparam logic [KIND_W-1:0] KIND_CONTROL   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PROGRAM   = 3'd4;
    localparam logic [KIND_W-1:0] KIND_CHAN_PRES = 3'd5;
    localparam logic [KIND_W-1:0] KIND_BEND      = 3'd6;

    typedef struct packed {
        logic              valid;
        logic [KIND_W-1:0] msg_kind;
        logic [CHAN_W-1:0] chan;
        logic [DATA_W-1:0] data_first;
        logic [DATA_W-1:0] data_second;
    } mmp_msg_t;

endpackage

`default_nettype wire

[design/mmp_decoder.sv]
// Parser state and per-byte decode logic for the MIDI message parser.
// Depends on mmp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmp_decoder (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      step,
    input  wire logic [mmp_pkg::BYTE_W-1:0] midi_byte,
    output mmp_pkg::mmp_msg_t              msg
);

    logic                        in_sysex_reg, in_sysex_next;
    logic                        pend_reg, pend_next;
    logic [mmp_pkg::KIND_W-1:0]  kind_reg, kind_next;
    logic [mmp_pkg::CHAN_W-1:0]  chan_reg, chan_next;
    logic [mmp_pkg::DATA_W-1:0]  held_reg, held_next;
    logic                        have_held_reg, have_held_next;

    always_comb begin
        in_sysex_next  = in_sysex_reg;
        pend_next      = pend_reg;
        kind_next      = kind_reg;
        chan_next      = chan_reg;
        held_next      = held_reg;
        have_held_next = have_held_reg;
        msg            = '0;

        if (in_sysex_reg) begin
            if (midi_byte == mmp_pkg::SYSEX_END) begin
                in_sysex_next = 1'b0;
            end
        end else if (midi_byte == mmp_pkg::SYSEX_START) begin
            in_sysex_next  = 1'b1;
            pend_next      = 1'b0;
            have_held_next = 1'b0;
        end else if (midi_byte[7:4] == mmp_pkg::SYSTEM_NIB) begin
            // other system bytes: drop, keep pending message
        end else if (midi_byte[7]) begin
            // new status abandons any unfinished message
            pend_next      = 1'b1;
            kind_next      = midi_byte[6:4];
            chan_next      = midi_byte[3:0];
            have_held_next = 1'b0;
        end else if (pend_reg) begin
            if (kind_reg == mmp_pkg::KIND_PROGRAM || kind_reg == mmp_pkg::KIND_CHAN_PRES) begin
                msg.valid       = 1'b1;
                msg.msg_kind    = kind_reg;
                msg.chan        = chan_reg;
                msg.data_first  = midi_byte[6:0];
                msg.data_second = '0;
                pend_next       = 1'b0;
                have_held_next  = 1'b0;
            end else if (!have_held_reg) begin
                held_next      = midi_byte[6:0];
                have_held_next = 1'b1;
            end else begin
                msg.valid       = 1'b1;
                msg.msg_kind    = (kind_reg == mmp_pkg::KIND_NOTE_ON && midi_byte[6:0] == '0)
                                  ? mmp_pkg::KIND_NOTE_OFF : kind_reg;
                msg.chan        = chan_reg;
                msg.data_first  = held_reg;
                msg.data_second = midi_byte[6:0];
                pend_next       = 1'b0;
                have_held_next  = 1'b0;
            end
        end
        if (!step) begin
            msg.valid = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_sysex_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            have_held_reg <= 1'b0;
        end else if (step) begin
            in_sysex_reg  <= in_sysex_next;
            pend_reg      <= pend_next;
            have_held_reg <= have_held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            kind_reg <= kind_next;
            chan_reg <= chan_next;
            held_reg <= held_next;
        end
    end

endmodule

`default_nettype wire

[design/midi_message_parser.sv]
// Top level of the MIDI message parser: input word register, decoder, result register.
// Depends on mmp_pkg and mmp_decoder.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Width  Contents
// s_       in   8      midi_byte, one received MIDI byte
// m_       out  24     msg_kind, chan, data_first, data_second (zero padded)
//
// One word is accepted every cycle while s_tready is high; throughput is one byte per cycle unless m_ stalls.
// Each byte passes through the input register, then the decode into the result register.
// A byte that completes a message yields one result word; all other bytes yield none.
// aresetn clears sysex mode, the pending status and both stage valid bits.
// A stall on m_ holds the result register; the input register keeps accepting
// until it too is full, then s_tready drops.

module midi_message_parser (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // [7:0] midi_byte
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [mmp_pkg::M_TDATA_W-1:0]      m_tdata    // [2:0] msg_kind, [6:3] chan,
                                                          // [13:7] data_first,
                                                          // [20:14] data_second
);

    logic                         in_valid_reg;
    logic [mmp_pkg::BYTE_W-1:0]   in_byte_reg;
    logic                         out_valid_reg;
    logic [mmp_pkg::MSG_W-1:0]    out_data_reg;
    logic                         advance;
    mmp_pkg::mmp_msg_t            msg;

    // decode stage moves when the result register is free or being drained
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

    mmp_decoder u_decoder (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (in_valid_reg && advance),
        .midi_byte (in_byte_reg),
        .msg       (msg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= msg.valid;
        end
    end

    // load the payload only for a completed message
    always_ff @(posedge aclk) begin
        if (advance && msg.valid) begin
            out_data_reg <= {msg.data_second, msg.data_first, msg.chan, msg.msg_kind};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(mmp_pkg::M_TDATA_W - mmp_pkg::MSG_W){1'b0}}, out_data_reg};

endmodule

`default_nettype wire
